// File: rtl/nirtx_pkg.sv
package nirtx_pkg;

  // counter width of the segment timer
  localparam int unsigned TIMER_BITS = 14;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // configuration register width and reset values
  localparam int unsigned REG_W = 14;
  localparam logic [REG_W-1:0] LEADER_MARK_RST  = REG_W'(9000);
  localparam logic [REG_W-1:0] LEADER_SPACE_RST = REG_W'(4500);
  localparam logic [REG_W-1:0] BIT_MARK_RST     = REG_W'(560);
  localparam logic [REG_W-1:0] ONE_SPACE_RST    = REG_W'(1680);
  localparam logic [REG_W-1:0] ZERO_SPACE_RST   = REG_W'(560);

  // register indexes on the configuration port (byte address = 4 * index)
  localparam int unsigned CFG_ADDR_W = 5;
  typedef enum logic [2:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4
  } reg_idx_t;

  // input mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // frame phases
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_STOP_MARK  = 3'd5
  } phase_t;

  localparam int unsigned BIT_IDX_W = 5;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = {BIT_IDX_W{1'b1}};

  // segment length: zero loads as one tick, too long saturates to the timer
  function automatic logic [TIMER_BITS-1:0] seg_len(input logic [REG_W-1:0] reg_val);
    localparam int unsigned W = (REG_W > TIMER_BITS) ? REG_W : TIMER_BITS;
    logic [W-1:0] v;
    v = W'(reg_val);
    if (v == '0) v = W'(1);
    if (v > W'(TIMER_MAX)) v = W'(TIMER_MAX);
    return TIMER_BITS'(v);
  endfunction

endpackage

// File: rtl/nirtx_if.sv
// input channel: start or tick transaction
interface nirtx_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] address;
  logic [7:0] command;

  modport source (output valid, output mode, output address, output command, input ready);
  modport sink   (input valid, input mode, input address, input command, output ready);
endinterface

// result channel: envelope level and status
interface nirtx_out_if;
  logic valid;
  logic ready;
  logic carrier_on;
  logic busy_res;
  logic start_rejected;

  modport source (output valid, output carrier_on, output busy_res, output start_rejected,
                  input ready);
  modport sink   (input valid, input carrier_on, input busy_res, input start_rejected,
                  output ready);
endinterface

// File: rtl/nec_ir_frame_transmitter_top.sv
// NEC infrared frame transmitter: produces the carrier-gate envelope of one NEC frame
// (leader mark, leader space, 32 bits LSB first as address, ~address, command, ~command,
// each a mark and a short or long space, then a stop mark). A start transaction (mode 0)
// loads address and command; each tick transaction (mode 1) is one microsecond and advances
// the frame. Every transaction yields exactly one result: carrier_on after the step, busy_res,
// and start_rejected for a start that arrives during a frame. The block takes one transaction
// per clock cycle; the result register sits behind a valid/ready handshake, so input is
// accepted whenever the result register is empty or being drained in the same cycle.
// Segment lengths come from five 14-bit APB registers at byte addresses 0, 4, 8, 12 and 16;
// a value of zero counts as one tick. Write registers only while no frame is running.
module nec_ir_frame_transmitter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  nirtx_in_if.sink                             in_ch,
  nirtx_out_if.source                          out_ch,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [nirtx_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [nirtx_pkg::REG_W-1:0] leader_mark_r, leader_space_r, bit_mark_r;
  logic [nirtx_pkg::REG_W-1:0] one_space_r, zero_space_r;

  nirtx_pkg::phase_t                  phase_r, phase_nxt, phase_cur;
  logic [nirtx_pkg::TIMER_BITS-1:0]   rem_r, rem_nxt, rem_dec;
  logic [nirtx_pkg::BIT_IDX_W-1:0]    bit_idx_r, bit_idx_nxt;
  logic [31:0]                        shift_r, shift_nxt;

  logic out_valid_r, carrier_r, busy_r, rejected_r;
  logic carrier_nxt, busy_nxt, rejected_nxt;
  logic in_acc, cfg_wr;

  // configuration write strobe and register index
  logic [2:0] cfg_idx;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[nirtx_pkg::CFG_ADDR_W-1:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_mark_r  <= nirtx_pkg::LEADER_MARK_RST;
      leader_space_r <= nirtx_pkg::LEADER_SPACE_RST;
      bit_mark_r     <= nirtx_pkg::BIT_MARK_RST;
      one_space_r    <= nirtx_pkg::ONE_SPACE_RST;
      zero_space_r   <= nirtx_pkg::ZERO_SPACE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        nirtx_pkg::REG_LEADER_MARK:  leader_mark_r  <= pwdata[nirtx_pkg::REG_W-1:0];
        nirtx_pkg::REG_LEADER_SPACE: leader_space_r <= pwdata[nirtx_pkg::REG_W-1:0];
        nirtx_pkg::REG_BIT_MARK:     bit_mark_r     <= pwdata[nirtx_pkg::REG_W-1:0];
        nirtx_pkg::REG_ONE_SPACE:    one_space_r    <= pwdata[nirtx_pkg::REG_W-1:0];
        nirtx_pkg::REG_ZERO_SPACE:   zero_space_r   <= pwdata[nirtx_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      nirtx_pkg::REG_LEADER_MARK:  prdata = 32'(leader_mark_r);
      nirtx_pkg::REG_LEADER_SPACE: prdata = 32'(leader_space_r);
      nirtx_pkg::REG_BIT_MARK:     prdata = 32'(bit_mark_r);
      nirtx_pkg::REG_ONE_SPACE:    prdata = 32'(one_space_r);
      nirtx_pkg::REG_ZERO_SPACE:   prdata = 32'(zero_space_r);
      default:                     prdata = '0;
    endcase
  end

  // handshake: take a transaction whenever the result slot is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // frame sequencer: next state and result for the current transaction
  always_comb begin
    phase_cur    = phase_r;
    phase_nxt    = phase_r;
    rem_nxt      = rem_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    rejected_nxt = 1'b0;
    rem_dec      = rem_r - nirtx_pkg::TIMER_BITS'(1);

    if (!(phase_r inside {nirtx_pkg::PH_LEAD_MARK, nirtx_pkg::PH_LEAD_SPACE,
                          nirtx_pkg::PH_BIT_MARK, nirtx_pkg::PH_BIT_SPACE,
                          nirtx_pkg::PH_STOP_MARK})) begin
      phase_cur = nirtx_pkg::PH_IDLE;
    end
    phase_nxt = phase_cur;

    if (in_ch.mode == nirtx_pkg::MODE_START) begin
      if (phase_cur != nirtx_pkg::PH_IDLE) begin
        rejected_nxt = 1'b1;
      end else begin
        shift_nxt   = {~in_ch.command, in_ch.command, ~in_ch.address, in_ch.address};
        bit_idx_nxt = '0;
        phase_nxt   = nirtx_pkg::PH_LEAD_MARK;
        rem_nxt     = nirtx_pkg::seg_len(leader_mark_r);
      end
    end else if (phase_cur != nirtx_pkg::PH_IDLE) begin
      rem_nxt = rem_dec;
      if (rem_dec == '0) begin
        case (phase_cur)
          nirtx_pkg::PH_LEAD_MARK: begin
            phase_nxt = nirtx_pkg::PH_LEAD_SPACE;
            rem_nxt   = nirtx_pkg::seg_len(leader_space_r);
          end
          nirtx_pkg::PH_LEAD_SPACE: begin
            phase_nxt   = nirtx_pkg::PH_BIT_MARK;
            bit_idx_nxt = '0;
            rem_nxt     = nirtx_pkg::seg_len(bit_mark_r);
          end
          nirtx_pkg::PH_BIT_MARK: begin
            phase_nxt = nirtx_pkg::PH_BIT_SPACE;
            rem_nxt   = nirtx_pkg::seg_len(shift_r[0] ? one_space_r : zero_space_r);
          end
          nirtx_pkg::PH_BIT_SPACE: begin
            phase_nxt = nirtx_pkg::PH_BIT_MARK;
            rem_nxt   = nirtx_pkg::seg_len(bit_mark_r);
            if (bit_idx_r == nirtx_pkg::LAST_BIT) begin
              phase_nxt = nirtx_pkg::PH_STOP_MARK;
            end else begin
              bit_idx_nxt = bit_idx_r + nirtx_pkg::BIT_IDX_W'(1);
              shift_nxt   = {1'b0, shift_r[31:1]};
            end
          end
          default: begin
            phase_nxt = nirtx_pkg::PH_IDLE;
            rem_nxt   = '0;
          end
        endcase
      end
    end

    carrier_nxt = (phase_nxt == nirtx_pkg::PH_LEAD_MARK) ||
                  (phase_nxt == nirtx_pkg::PH_BIT_MARK)  ||
                  (phase_nxt == nirtx_pkg::PH_STOP_MARK);
    busy_nxt    = (phase_nxt != nirtx_pkg::PH_IDLE);
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= nirtx_pkg::PH_IDLE;
      rem_r     <= '0;
      bit_idx_r <= '0;
      shift_r   <= '0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      carrier_r  <= carrier_nxt;
      busy_r     <= busy_nxt;
      rejected_r <= rejected_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.carrier_on     = carrier_r;
  assign out_ch.busy_res       = busy_r;
  assign out_ch.start_rejected = rejected_r;

  // carrier is only gated on during a frame
  a_carrier_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!carrier_r || busy_r))
    else $error("carrier on without busy");

  // a rejected start only happens during a frame
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rejected_r) |-> busy_r)
    else $error("start rejected while idle");

  // a running segment always has ticks left
  a_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != nirtx_pkg::PH_IDLE) |-> (rem_r != '0))
    else $error("active phase with empty timer");

  // an accepted start while idle opens the leader mark
  a_start_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.mode == nirtx_pkg::MODE_START && phase_r == nirtx_pkg::PH_IDLE)
    |=> (phase_r == nirtx_pkg::PH_LEAD_MARK))
    else $error("start did not enter leader mark");

endmodule

// File: dv/tb_top.sv
module tb_top;

  localparam int unsigned NUM_REGS    = 5;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned QUEUE_DEPTH = 16;

  typedef struct packed {
    logic       mode;
    logic [7:0] address;
    logic [7:0] command;
  } ir_item_t;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic start_rejected;
  } ir_level_t;

  logic clk;
  logic rst_n;

  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [nirtx_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                      pwdata;
  logic [31:0]                      prdata;
  logic                             pready;

  nirtx_in_if  in_ch();
  nirtx_out_if out_ch();

  nec_ir_frame_transmitter_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock, period 8
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stimulus and expectation stores
  ir_item_t    pending_items[$];
  ir_level_t   expected_levels[$];
  int unsigned idle_pct = 15;
  int unsigned useful_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned stall_cycles = 0;

  // shadow of the segment length registers
  logic [nirtx_pkg::REG_W-1:0] ticks_cfg [NUM_REGS] = '{nirtx_pkg::LEADER_MARK_RST,
                                                        nirtx_pkg::LEADER_SPACE_RST,
                                                        nirtx_pkg::BIT_MARK_RST,
                                                        nirtx_pkg::ONE_SPACE_RST,
                                                        nirtx_pkg::ZERO_SPACE_RST};

  // envelope generator state
  nirtx_pkg::phase_t                fr_phase   = nirtx_pkg::PH_IDLE;
  logic [nirtx_pkg::TIMER_BITS-1:0] seg_left   = '0;
  logic [nirtx_pkg::BIT_IDX_W-1:0]  bit_no     = '0;
  logic [31:0]                      frame_bits = '0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < 40)
      $display("mismatch at result %0d: %s got %0h expected %0h", result_count, what, got,
               want);
    mismatch_count++;
  endtask

  // register value to segment length in ticks
  function automatic logic [nirtx_pkg::TIMER_BITS-1:0] seg_ticks(
      input logic [nirtx_pkg::REG_W-1:0] v);
    if (v == '0) return nirtx_pkg::TIMER_BITS'(1);
    if (32'(v) > 32'(nirtx_pkg::TIMER_MAX)) return nirtx_pkg::TIMER_MAX;
    return nirtx_pkg::TIMER_BITS'(v);
  endfunction

  // number of ticks a frame lasts under the current register values
  function automatic int unsigned frame_ticks(input logic [7:0] a, input logic [7:0] c);
    logic [31:0] bits;
    int unsigned n;
    bits = {~c, c, ~a, a};
    n = seg_ticks(ticks_cfg[nirtx_pkg::REG_LEADER_MARK])
        + seg_ticks(ticks_cfg[nirtx_pkg::REG_LEADER_SPACE])
        + seg_ticks(ticks_cfg[nirtx_pkg::REG_BIT_MARK]);
    for (int i = 0; i < 32; i++)
      n += seg_ticks(ticks_cfg[nirtx_pkg::REG_BIT_MARK])
           + seg_ticks(bits[i] ? ticks_cfg[nirtx_pkg::REG_ONE_SPACE]
                               : ticks_cfg[nirtx_pkg::REG_ZERO_SPACE]);
    return n;
  endfunction

  // one transaction through the envelope generator, returns the level after it
  function automatic ir_level_t envelope_step(input ir_item_t it);
    ir_level_t lv;
    logic      rejected;
    rejected = 1'b0;
    if (it.mode == nirtx_pkg::MODE_START) begin
      if (fr_phase != nirtx_pkg::PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        frame_bits = {~it.command, it.command, ~it.address, it.address};
        bit_no     = '0;
        fr_phase   = nirtx_pkg::PH_LEAD_MARK;
        seg_left   = seg_ticks(ticks_cfg[nirtx_pkg::REG_LEADER_MARK]);
        useful_items++;
      end
    end else if (fr_phase != nirtx_pkg::PH_IDLE) begin
      useful_items++;
      seg_left = seg_left - 1'b1;
      if (seg_left == '0) begin
        case (fr_phase)
          nirtx_pkg::PH_LEAD_MARK: begin
            fr_phase = nirtx_pkg::PH_LEAD_SPACE;
            seg_left = seg_ticks(ticks_cfg[nirtx_pkg::REG_LEADER_SPACE]);
          end
          nirtx_pkg::PH_LEAD_SPACE: begin
            fr_phase = nirtx_pkg::PH_BIT_MARK;
            bit_no   = '0;
            seg_left = seg_ticks(ticks_cfg[nirtx_pkg::REG_BIT_MARK]);
          end
          nirtx_pkg::PH_BIT_MARK: begin
            fr_phase = nirtx_pkg::PH_BIT_SPACE;
            seg_left = seg_ticks(frame_bits[0] ? ticks_cfg[nirtx_pkg::REG_ONE_SPACE]
                                               : ticks_cfg[nirtx_pkg::REG_ZERO_SPACE]);
          end
          nirtx_pkg::PH_BIT_SPACE: begin
            if (bit_no == nirtx_pkg::LAST_BIT) begin
              fr_phase = nirtx_pkg::PH_STOP_MARK;
            end else begin
              bit_no     = bit_no + 1'b1;
              frame_bits = frame_bits >> 1;
              fr_phase   = nirtx_pkg::PH_BIT_MARK;
            end
            seg_left = seg_ticks(ticks_cfg[nirtx_pkg::REG_BIT_MARK]);
          end
          default: begin
            fr_phase = nirtx_pkg::PH_IDLE;
            seg_left = '0;
          end
        endcase
      end
    end
    lv.carrier_on     = (fr_phase == nirtx_pkg::PH_LEAD_MARK) ||
                        (fr_phase == nirtx_pkg::PH_BIT_MARK) ||
                        (fr_phase == nirtx_pkg::PH_STOP_MARK);
    lv.busy_res       = (fr_phase != nirtx_pkg::PH_IDLE);
    lv.start_rejected = rejected;
    return lv;
  endfunction

  // input driver
  always @(posedge clk) begin : in_driver
    ir_item_t next_item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        next_item = pending_items.pop_front();
        in_ch.mode    <= next_item.mode;
        in_ch.address <= next_item.address;
        in_ch.command <= next_item.command;
        in_ch.valid   <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink with random back-pressure
  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= idle_pct);
  end

  // prediction on accepted input, comparison on accepted result, watchdog
  always @(posedge clk) begin : result_check
    ir_item_t  seen;
    ir_level_t want;
    logic      moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        seen.mode    = in_ch.mode;
        seen.address = in_ch.address;
        seen.command = in_ch.command;
        expected_levels.push_back(envelope_step(seen));
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (expected_levels.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = expected_levels.pop_front();
          if (out_ch.carrier_on !== want.carrier_on)
            report_mismatch("carrier_on", out_ch.carrier_on, want.carrier_on);
          if (out_ch.busy_res !== want.busy_res)
            report_mismatch("busy_res", out_ch.busy_res, want.busy_res);
          if (out_ch.start_rejected !== want.start_rejected)
            report_mismatch("start_rejected", out_ch.start_rejected, want.start_rejected);
        end
        result_count++;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("timeout with %0d results pending", expected_levels.size());
        $display("nec_ir_frame_transmitter_top verification failed");
        $finish;
      end
    end
  end

  task automatic push_item(input logic mode, input logic [7:0] a, input logic [7:0] c);
    ir_item_t it;
    it.mode    = mode;
    it.address = a;
    it.command = c;
    pending_items.push_back(it);
    while (pending_items.size() > QUEUE_DEPTH) @(negedge clk);
  endtask

  task automatic push_ticks(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_item(nirtx_pkg::MODE_TICK, 8'($urandom), 8'($urandom));
  endtask

  // one register transaction: setup cycle, then access until pready
  task automatic cfg_access(input logic wr, input int unsigned idx, input logic [31:0] value,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= nirtx_pkg::CFG_ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && idx < NUM_REGS) ticks_cfg[idx] = value[nirtx_pkg::REG_W-1:0];
  endtask

  task automatic cfg_readback();
    logic [31:0] rdata;
    for (int unsigned i = 0; i < NUM_REGS; i++) begin
      cfg_access(1'b0, i, $urandom, rdata);
      if (rdata !== 32'(ticks_cfg[i])) report_mismatch("register readback", rdata, ticks_cfg[i]);
    end
  endtask

  // writes all five lengths, upper data bits random since only 14 are kept, then reads them back
  task automatic apply_config(input logic [nirtx_pkg::REG_W-1:0] lm,
                              input logic [nirtx_pkg::REG_W-1:0] ls,
                              input logic [nirtx_pkg::REG_W-1:0] bm,
                              input logic [nirtx_pkg::REG_W-1:0] os,
                              input logic [nirtx_pkg::REG_W-1:0] zs);
    logic [nirtx_pkg::REG_W-1:0] vals [NUM_REGS];
    logic [31:0]                 rdata;
    vals = '{lm, ls, bm, os, zs};
    for (int unsigned i = 0; i < NUM_REGS; i++)
      cfg_access(1'b1, i, {18'($urandom), vals[i]}, rdata);
    cfg_readback();
  endtask

  // wait for every result, finishing any frame still running, so the block is idle
  task automatic settle();
    forever begin
      while (pending_items.size() != 0 || in_ch.valid || expected_levels.size() != 0)
        @(negedge clk);
      if (fr_phase == nirtx_pkg::PH_IDLE) break;
      push_ticks(64);
    end
    repeat (4) @(negedge clk);
  endtask

  // well-formed frames with random content, some cut short, some stray starts
  task automatic run_frames(input int unsigned target);
    int unsigned base;
    int unsigned len;
    int unsigned n;
    logic [7:0]  a;
    logic [7:0]  c;
    base = useful_items;
    while (useful_items - base < target) begin
      a = 8'($urandom);
      c = 8'($urandom);
      push_item(nirtx_pkg::MODE_START, a, c);
      len = frame_ticks(a, c);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, len - 1);
      else n = len - 1 + $urandom_range(0, 3);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 3)
          push_item(nirtx_pkg::MODE_START, 8'($urandom), 8'($urandom));
        push_item(nirtx_pkg::MODE_TICK, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [31:0] rdata;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = nirtx_pkg::MODE_TICK;
    in_ch.address = '0;
    in_ch.command = '0;
    out_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, ticks while idle
    cfg_readback();
    push_item(nirtx_pkg::MODE_TICK, 8'hFF, 8'h00);
    push_item(nirtx_pkg::MODE_TICK, 8'h00, 8'hFF);
    settle();

    // zero lengths load as one tick; writes past the register list change nothing
    apply_config('0, '0, '0, '0, '0);
    for (int unsigned k = NUM_REGS; k < 8; k++) cfg_access(1'b1, k, 32'hFFFF_FFFF, rdata);
    cfg_readback();
    push_item(nirtx_pkg::MODE_START, 8'h00, 8'hFF);
    push_item(nirtx_pkg::MODE_START, 8'hFF, 8'h00);
    push_ticks(frame_ticks(8'h00, 8'hFF));
    push_item(nirtx_pkg::MODE_START, 8'hFF, 8'h00);
    push_ticks(frame_ticks(8'hFF, 8'h00) - 1);
    push_item(nirtx_pkg::MODE_START, 8'h5A, 8'hA5);
    push_item(nirtx_pkg::MODE_TICK, 8'hA5, 8'h5A);
    push_item(nirtx_pkg::MODE_TICK, 8'hFF, 8'hFF);
    settle();

    // back-to-back stretch without idling on either side
    idle_pct = 0;
    apply_config(nirtx_pkg::REG_W'($urandom_range(0, 8)), nirtx_pkg::REG_W'($urandom_range(0, 8)),
                 nirtx_pkg::REG_W'($urandom_range(0, 8)), nirtx_pkg::REG_W'($urandom_range(0, 8)),
                 nirtx_pkg::REG_W'($urandom_range(0, 8)));
    run_frames(200);
    settle();
    idle_pct = 15;

    // long leader mark and space against one-tick bit marks and zero spaces and two-tick one spaces
    apply_config(nirtx_pkg::REG_W'(60), nirtx_pkg::REG_W'(30), nirtx_pkg::REG_W'(1),
                 nirtx_pkg::REG_W'(2), nirtx_pkg::REG_W'(0));
    push_item(nirtx_pkg::MODE_START, 8'hC3, 8'h3C);
    push_ticks(frame_ticks(8'hC3, 8'h3C));
    settle();

    // random short settings
    for (int unsigned p = 0; p < 2; p++) begin
      apply_config(nirtx_pkg::REG_W'($urandom_range(0, 3)),
                   nirtx_pkg::REG_W'($urandom_range(0, 3)),
                   nirtx_pkg::REG_W'($urandom_range(0, 3)),
                   nirtx_pkg::REG_W'($urandom_range(0, 3)),
                   nirtx_pkg::REG_W'($urandom_range(0, 3)));
      run_frames(100);
      settle();
    end

    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("nec_ir_frame_transmitter_top verification clean");
    end else begin
      $display("nec_ir_frame_transmitter_top verification failed");
    end
    $finish;
  end

endmodule
